// ----- rtl/core/lfu_pkg.sv -----
// lfu_pkg: shared types and constants for the lfu cache block
// depends on nothing; used by every module under rtl/core
package lfu_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CAP_BITS       = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  // request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_AGE
  } eng_state_t;

endpackage

// ----- rtl/core/lfu_queue.sv -----
// lfu_queue: two-entry request queue between the front port and the engine
// depends on lfu_pkg
module lfu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  lfu_pkg::req_t wr_data,
  output logic          rd_valid,
  input  logic          rd_take,
  output lfu_pkg::req_t rd_data
);

  lfu_pkg::req_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && rd_take;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

// ----- rtl/core/lfu_engine.sv -----
// lfu_engine: scans the entries one a cycle, then applies hit, update or insert
// depends on lfu_pkg
module lfu_engine #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lfu_pkg::CAP_BITS-1:0]  capacity,
  input  logic                          req_valid,
  output logic                          req_take,
  input  lfu_pkg::req_t                 req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output lfu_pkg::rsp_t                 rsp_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // entry state
  logic [ENTRIES-1:0]  valid_r;
  logic [31:0]         key_r  [ENTRIES];
  logic [31:0]         data_r [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_r [ENTRIES];
  logic [RW-1:0]       rank_r [ENTRIES];
  logic [OW-1:0]       occ_r;

  lfu_pkg::eng_state_t st_r, st_nxt;
  lfu_pkg::req_t       cur_r;
  logic [IW-1:0]       idx_r;
  logic                found_r, vfound_r, free_found_r;
  logic [IW-1:0]       hit_idx_r, vic_idx_r, free_idx_r;
  logic [COUNT_BITS-1:0] vic_cnt_r;
  logic [RW-1:0]       vic_rank_r;
  logic [RW-1:0]       touch_rank_r;
  logic                touch_r;
  logic                age_all_r;
  logic [IW-1:0]       slot_r;
  logic                out_v_r;
  lfu_pkg::rsp_t       out_r;

  logic [OW-1:0] cap_eff;
  logic          last;
  assign cap_eff = ({{(OW > lfu_pkg::CAP_BITS ? OW - lfu_pkg::CAP_BITS : 0){1'b0}}, capacity}
                    > (lfu_pkg::CAP_BITS + OW)'(ENTRIES)) ? OW'(ENTRIES) : OW'(capacity);
  assign last = (idx_r == IW'(ENTRIES - 1));

  assign rsp_valid = out_v_r;
  assign rsp_data  = out_r;
  assign req_take  = (st_r == lfu_pkg::ST_IDLE) && req_valid && !(out_v_r && rsp_stall);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      lfu_pkg::ST_IDLE:  if (req_take) st_nxt = lfu_pkg::ST_SCAN;
      lfu_pkg::ST_SCAN:  if (last) st_nxt = lfu_pkg::ST_APPLY;
      lfu_pkg::ST_APPLY: st_nxt = lfu_pkg::ST_AGE;
      lfu_pkg::ST_AGE:   st_nxt = lfu_pkg::ST_IDLE;
      default:           st_nxt = lfu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= lfu_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (st_r == lfu_pkg::ST_APPLY) out_v_r <= 1'b1;
    else if (!rsp_stall) out_v_r <= 1'b0;
  end

  // scan, apply and ageing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else begin
      case (st_r)
        lfu_pkg::ST_IDLE: begin
          if (req_take) begin
            cur_r        <= req_data;
            idx_r        <= '0;
            found_r      <= 1'b0;
            vfound_r     <= 1'b0;
            free_found_r <= 1'b0;
          end
        end
        lfu_pkg::ST_SCAN: begin
          if (valid_r[idx_r]) begin
            if (!found_r && key_r[idx_r] == cur_r.key) begin
              found_r   <= 1'b1;
              hit_idx_r <= idx_r;
            end
            if (!vfound_r || cnt_r[idx_r] < vic_cnt_r ||
                (cnt_r[idx_r] == vic_cnt_r && rank_r[idx_r] > vic_rank_r)) begin
              vfound_r   <= 1'b1;
              vic_idx_r  <= idx_r;
              vic_cnt_r  <= cnt_r[idx_r];
              vic_rank_r <= rank_r[idx_r];
            end
          end else if (!free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= idx_r;
          end
          idx_r <= idx_r + 1'b1;
        end
        lfu_pkg::ST_APPLY: begin
          if (found_r && (cur_r.req_type == lfu_pkg::REQ_GET || cap_eff != '0)) begin
            out_r.hit        <= 1'b1;
            out_r.read_value <= (cur_r.req_type == lfu_pkg::REQ_GET) ?
                                data_r[hit_idx_r] : lfu_pkg::MISS_VALUE;
            if (cur_r.req_type == lfu_pkg::REQ_PUT) data_r[hit_idx_r] <= cur_r.value;
            if (cnt_r[hit_idx_r] != CNT_MAX) cnt_r[hit_idx_r] <= cnt_r[hit_idx_r] + 1'b1;
            touch_rank_r <= rank_r[hit_idx_r];
            touch_r      <= 1'b1;
            age_all_r    <= 1'b0;
            slot_r       <= hit_idx_r;
          end else begin
            out_r.hit        <= 1'b0;
            out_r.read_value <= lfu_pkg::MISS_VALUE;
            if (!found_r && cur_r.req_type == lfu_pkg::REQ_PUT && cap_eff != '0 &&
                occ_r >= cap_eff && vfound_r) begin
              // full: reuse the victim slot, ranks stay a dense order
              slot_r             <= vic_idx_r;
              data_r[vic_idx_r]  <= cur_r.value;
              key_r[vic_idx_r]   <= cur_r.key;
              cnt_r[vic_idx_r]   <= COUNT_BITS'(1);
              touch_rank_r       <= vic_rank_r;
              touch_r            <= 1'b1;
              age_all_r          <= 1'b0;
            end else if (!found_r && cur_r.req_type == lfu_pkg::REQ_PUT &&
                         cap_eff != '0 && free_found_r) begin
              // room left: take the first free slot
              slot_r             <= free_idx_r;
              data_r[free_idx_r] <= cur_r.value;
              key_r[free_idx_r]  <= cur_r.key;
              cnt_r[free_idx_r]  <= COUNT_BITS'(1);
              touch_rank_r       <= '0;
              touch_r            <= 1'b0;
              age_all_r          <= 1'b1;
              occ_r              <= occ_r + 1'b1;
            end else begin
              slot_r       <= '0;
              touch_rank_r <= '0;
              touch_r      <= 1'b0;
              age_all_r    <= 1'b0;
            end
          end
        end
        lfu_pkg::ST_AGE: begin
          // recency update over all entries in parallel
          for (int i = 0; i < ENTRIES; i++) begin
            if (age_all_r) begin
              if (valid_r[i] && IW'(i) != slot_r) rank_r[i] <= rank_r[i] + 1'b1;
            end else if (touch_r && valid_r[i] && IW'(i) != slot_r &&
                         rank_r[i] < touch_rank_r) begin
              rank_r[i] <= rank_r[i] + 1'b1;
            end
          end
          if (age_all_r || touch_r) rank_r[slot_r] <= '0;
          if (age_all_r) valid_r[slot_r] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/lfu_cache_with_lru_tiebreak_unit.sv -----
// lfu_cache_with_lru_tiebreak_unit: top level, APB register, queue and engine
// depends on lfu_pkg, lfu_queue, lfu_engine
//
// usage: requests (get or put) enter on the in_ channel as one beat each and
// pass through a two-deep queue to the engine. The engine scans all ENTRIES
// slots one per cycle for key match, free slot and LFU victim (LRU on ties),
// then applies the update and ages recency ranks; it finishes one request
// before taking the next. One result beat per request leaves on out_ from an
// output register. While out_stall is high with a result waiting, the engine
// holds that result and takes no new request; the queue still accepts up to
// two beats. Reset empties the cache, clears the queue and sets capacity to
// 16; no clearing pass is needed. Capacity sits at address 0; the user must
// write it only while the block is idle, and the block does not enforce this.
module lfu_cache_with_lru_tiebreak_unit #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lfu_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lfu_pkg::rsp_t out_data,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [1:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  logic [lfu_pkg::CAP_BITS-1:0] cap_r;
  logic          q_valid, q_take;
  lfu_pkg::req_t q_data;

  // capacity register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {{(32-lfu_pkg::CAP_BITS){1'b0}}, cap_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= lfu_pkg::CAP_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      cap_r <= cfg_pwdata[lfu_pkg::CAP_BITS-1:0];
  end

  lfu_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_stall(in_stall), .wr_data(in_data),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
  );

  lfu_engine #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n), .capacity(cap_r),
    .req_valid(q_valid), .req_take(q_take), .req_data(q_data),
    .rsp_valid(out_valid), .rsp_stall(out_stall), .rsp_data(out_data)
  );

endmodule

// ----- sim/tb.sv -----
// tb: self-checking bench for lfu_cache_with_lru_tiebreak_unit
// drives get/put beats and apb capacity writes, predicts results in a local model
// depends on lfu_pkg and the rtl under rtl/core
module tb;

  localparam int NSLOT = lfu_pkg::ENTRIES_DEF;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  lfu_pkg::req_t in_data;
  lfu_pkg::rsp_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  lfu_cache_with_lru_tiebreak_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // cache shadow
  logic [4:0]  shadow_cap;
  bit          slot_valid [NSLOT];
  logic [31:0] slot_key [NSLOT];
  logic [31:0] slot_data [NSLOT];
  logic [15:0] slot_count [NSLOT];
  int unsigned slot_age [NSLOT];
  int          slot_fill;

  lfu_pkg::req_t pending_req [$];
  lfu_pkg::rsp_t expected_rsp [$];
  int   errors;
  int   cycles;
  logic quiet;
  int   in_gap, out_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("error at cycle %0d: %s", cycles, what);
  endtask

  function automatic void mark_recent(input int s);
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // lfu lookup/update for one request
  function automatic lfu_pkg::rsp_t cache_access(input lfu_pkg::req_t r);
    lfu_pkg::rsp_t res;
    int cap, s, v;
    res.hit = 1'b0;
    res.read_value = lfu_pkg::MISS_VALUE;
    cap = (shadow_cap > NSLOT) ? NSLOT : int'(shadow_cap);
    s = -1;
    for (int i = NSLOT - 1; i >= 0; i--)
      if (slot_valid[i] && slot_key[i] == r.key) s = i;
    if (r.req_type == lfu_pkg::REQ_GET) begin
      if (s >= 0) begin
        res.hit = 1'b1;
        res.read_value = slot_data[s];
        if (slot_count[s] < CNT_MAX) slot_count[s]++;
        mark_recent(s);
      end
    end else if (cap != 0) begin
      if (s >= 0) begin
        res.hit = 1'b1;
        slot_data[s] = r.value;
        if (slot_count[s] < CNT_MAX) slot_count[s]++;
        mark_recent(s);
      end else begin
        v = -1;
        if (slot_fill >= cap) begin
          for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && (v < 0 || slot_count[i] < slot_count[v] ||
                (slot_count[i] == slot_count[v] && slot_age[i] > slot_age[v])))
              v = i;
          if (v >= 0) begin
            slot_valid[v] = 1'b0;
            if (slot_fill > 0) slot_fill--;
          end
        end
        if (v < 0)
          for (int i = NSLOT - 1; i >= 0; i--)
            if (!slot_valid[i]) v = i;
        if (v >= 0) begin
          for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i]) slot_age[i]++;
          slot_valid[v] = 1'b1;
          slot_key[v] = r.key;
          slot_data[v] = r.value;
          slot_count[v] = 16'd1;
          slot_age[v] = 0;
          slot_fill++;
        end
      end
    end
    return res;
  endfunction

  // driver: pops pending requests, random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (in_valid && !in_stall) begin
      expected_rsp.push_back(cache_access(in_data));
      if (!quiet && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        in_gap <= $urandom_range(1, 16);
      end else if (pending_req.size() > 0) begin
        in_data <= pending_req.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_req.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_req.pop_front();
      end
    end
  end

  // monitor: checks result beats, random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          lfu_pkg::rsp_t e;
          e = expected_rsp.pop_front();
          if (out_data.hit !== e.hit)
            report($sformatf("hit %b, expected %b", out_data.hit, e.hit));
          if (out_data.read_value !== e.read_value)
            report($sformatf("read_value %h, expected %h",
                             out_data.read_value, e.read_value));
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lfu_cache_with_lru_tiebreak_unit: mismatch");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_req.size() > 0 || in_valid || expected_rsp.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_CAPACITY;
    cfg_pwdata <= {27'd0, cap};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    shadow_cap = cap;
    @(posedge clk);
  endtask

  function automatic lfu_pkg::req_t make_req(input logic t, input logic [31:0] k,
                                             input logic [31:0] d);
    lfu_pkg::req_t r;
    r.req_type = t;
    r.key = k;
    r.value = d;
    return r;
  endfunction

  // random traffic over a small key pool so hits and evictions are common
  task automatic add_random(input int n, input int pool);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) k = $urandom();
      else k = 32'h5A00_0000 + $urandom_range(0, pool - 1);
      pending_req.push_back(make_req(1'($urandom_range(0, 1)), k, $urandom()));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    quiet = 1'b0;
    shadow_cap = lfu_pkg::CAP_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, miss, insert, hit, update
    pending_req.push_back(make_req(lfu_pkg::REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF));
    pending_req.push_back(make_req(lfu_pkg::REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_req.push_back(make_req(lfu_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_req.push_back(make_req(lfu_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000));
    pending_req.push_back(make_req(lfu_pkg::REQ_GET, 32'h8000_0000, 32'h0));
    pending_req.push_back(make_req(lfu_pkg::REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_req.push_back(make_req(lfu_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    pending_req.push_back(make_req(lfu_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0));
    wait_drained();

    // tiny capacity: lfu victim, lru on equal counts
    write_capacity(5'd2);
    pending_req.push_back(make_req(lfu_pkg::REQ_PUT, 32'd1, 32'd11));
    pending_req.push_back(make_req(lfu_pkg::REQ_PUT, 32'd2, 32'd22));
    pending_req.push_back(make_req(lfu_pkg::REQ_PUT, 32'd3, 32'd33));
    pending_req.push_back(make_req(lfu_pkg::REQ_GET, 32'd1, 32'd0));
    pending_req.push_back(make_req(lfu_pkg::REQ_GET, 32'd3, 32'd0));
    pending_req.push_back(make_req(lfu_pkg::REQ_PUT, 32'd4, 32'd44));
    pending_req.push_back(make_req(lfu_pkg::REQ_GET, 32'd2, 32'd0));
    wait_drained();

    // capacity zero ignores puts, gets still hit older entries
    write_capacity(5'd0);
    pending_req.push_back(make_req(lfu_pkg::REQ_PUT, 32'd9, 32'd99));
    pending_req.push_back(make_req(lfu_pkg::REQ_GET, 32'd9, 32'd0));
    pending_req.push_back(make_req(lfu_pkg::REQ_GET, 32'd3, 32'd0));
    pending_req.push_back(make_req(lfu_pkg::REQ_PUT, 32'd3, 32'd77));
    wait_drained();

    // capacity above the slot count acts as full size
    write_capacity(5'd31);
    add_random(250, 40);
    wait_drained();

    // lowered below occupancy
    write_capacity(5'd3);
    add_random(200, 8);
    wait_drained();

    write_capacity(5'd1);
    add_random(80, 4);
    wait_drained();

    write_capacity(5'd16);
    add_random(300, 24);
    wait_drained();

    // hammer one key for count growth, then run without idling
    write_capacity(5'd8);
    for (int i = 0; i < 40; i++)
      pending_req.push_back(make_req(lfu_pkg::REQ_GET, 32'h5A00_0001, 32'd0));
    add_random(100, 16);
    while (pending_req.size() > 0) @(posedge clk);
    quiet = 1'b1;
    add_random(150, 12);
    wait_drained();

    if (errors == 0) begin
      $display("lfu_cache_with_lru_tiebreak_unit: match");
    end else begin
      $display("lfu_cache_with_lru_tiebreak_unit: mismatch");
    end
    $finish;
  end

endmodule
